FILE: rtl/sorted_record_block_index_assert.svh
// Assertion macros for the sorted record block index.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef SORTED_RECORD_BLOCK_INDEX_ASSERT_SVH
`define SORTED_RECORD_BLOCK_INDEX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRBI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted record block index: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRBI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted record block index: next-cycle check failed");

`endif

FILE: rtl/srbi_pkg.sv
// Package for the sorted record block index: sizes, command codes, entry
// layout, controller states and the controller/datapath signal groups.
package srbi_pkg;

  localparam int MAX_ENTRIES  = 256;
  localparam int INDEX_BYTES  = 24;
  localparam int HEADER_BYTES = 24;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int CMD_W  = 2;
  localparam int TIME_W = 64;
  localparam int LEN_W  = 16;
  localparam int POS_W  = 8;
  localparam int OFF_W  = 16;
  localparam int TOT_W  = 9;
  localparam int BB_W   = 17;
  localparam int NEED_W = BB_W + 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [BB_W-1:0] BLOCK_LIMIT = 17'd65536;
  localparam logic [BB_W-1:0] BB_RESET    = 17'd4096;
  localparam logic [BB_W-1:0] HEAD_RESET  = BB_W'(4096 - HEADER_BYTES);

  typedef struct packed {
    logic [TIME_W-1:0] rec_time;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  rec_len;
  } srbi_entry_t;

  localparam int ENTRY_W = $bits(srbi_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT,
    ST_PLACE,
    ST_READ_RD,
    ST_READ_CAP,
    ST_FINISH
  } srbi_state_t;

  typedef struct packed {
    logic load;
    logic ins_start;
    logic res_zero;
    logic clear;
    logic probe;
    logic compare;
    logic shift_init;
    logic shift;
    logic place;
    logic rd_issue;
    logic rd_cap;
    logic finish;
  } srbi_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             fits;
    logic             pos_ok;
    logic             span_zero;
    logic             shift_done;
    logic             out_free;
  } srbi_sts_t;

endpackage

FILE: rtl/srbi_if.sv
// Handshake channels of the sorted record block index: request and response.
// Depends on srbi_pkg for the field widths.
interface srbi_in_if;
  logic                         valid;
  logic                         ready;
  logic [srbi_pkg::CMD_W-1:0]   cmd;
  logic [srbi_pkg::TIME_W-1:0]  rec_time;
  logic [srbi_pkg::LEN_W-1:0]   rec_len;
  logic [srbi_pkg::POS_W-1:0]   entry_pos;

  modport source (output valid, cmd, rec_time, rec_len, entry_pos, input ready);
  modport sink (input valid, cmd, rec_time, rec_len, entry_pos, output ready);
endinterface

interface srbi_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [srbi_pkg::OFF_W-1:0]   data_offset;
  logic [srbi_pkg::TIME_W-1:0]  out_time;
  logic [srbi_pkg::LEN_W-1:0]   out_len;
  logic [srbi_pkg::TOT_W-1:0]   entry_total;

  modport source (output valid, ok, data_offset, out_time, out_len, entry_total,
                  input ready);
  modport sink (input valid, ok, data_offset, out_time, out_len, entry_total,
                output ready);
endinterface

FILE: rtl/srbi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/srbi_ctrl.sv
// Controller of the sorted record block index: sequences decode, binary
// search, entry shift, placement, reads and result hand-off. Uses srbi_pkg.
module srbi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srbi_pkg::srbi_sts_t sts,
  output srbi_pkg::srbi_ctl_t ctl
);
  import srbi_pkg::*;

  srbi_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.cmd)
          CMD_INSERT: state_next = sts.fits ? ST_SRCH_RD : ST_FINISH;
          CMD_READ:   state_next = sts.pos_ok ? ST_READ_RD : ST_FINISH;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_SRCH_RD:  state_next = sts.span_zero ? ST_SHIFT : ST_SRCH_CMP;
      ST_SRCH_CMP: state_next = ST_SRCH_RD;
      ST_SHIFT: begin
        if (sts.shift_done) state_next = ST_PLACE;
      end
      ST_PLACE:    state_next = ST_FINISH;
      ST_READ_RD:  state_next = ST_READ_CAP;
      ST_READ_CAP: state_next = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_DECODE: begin
        unique case (sts.cmd)
          CMD_INSERT: begin
            ctl.ins_start = sts.fits;
            ctl.res_zero  = !sts.fits;
          end
          CMD_READ:  ctl.res_zero = !sts.pos_ok;
          CMD_CLEAR: ctl.clear = 1'b1;
          default:   ctl.res_zero = 1'b1;
        endcase
      end
      ST_SRCH_RD: begin
        ctl.shift_init = sts.span_zero;
        ctl.probe      = !sts.span_zero;
      end
      ST_SRCH_CMP: ctl.compare  = 1'b1;
      ST_SHIFT:    ctl.shift    = 1'b1;
      ST_PLACE:    ctl.place    = 1'b1;
      ST_READ_RD:  ctl.rd_issue = 1'b1;
      ST_READ_CAP: ctl.rd_cap   = 1'b1;
      ST_FINISH:   ctl.finish   = sts.out_free;
      default:     ctl = '0;
    endcase
  end

endmodule

FILE: rtl/srbi_dpath.sv
// Datapath of the sorted record block index: block state, search and shift
// pointers, the entry table memory and the result register. Uses srbi_pkg.
module srbi_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [srbi_pkg::BB_W-1:0]    cfg_wdata,
  input  logic [srbi_pkg::CMD_W-1:0]   in_cmd,
  input  logic [srbi_pkg::TIME_W-1:0]  in_time,
  input  logic [srbi_pkg::LEN_W-1:0]   in_len,
  input  logic [srbi_pkg::POS_W-1:0]   in_pos,
  input  srbi_pkg::srbi_ctl_t          ctl,
  output srbi_pkg::srbi_sts_t          sts,
  srbi_out_if.source                   rsp
);
  import srbi_pkg::*;

  logic [BB_W-1:0]   block_bytes;
  logic [CNT_W-1:0]  count;
  logic [BB_W-1:0]   head;
  logic [CMD_W-1:0]  cmd;
  logic [TIME_W-1:0] key;
  logic [LEN_W-1:0]  len;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  ptr;
  logic              wr_pend;
  logic [IDX_W-1:0]  wr_addr;
  logic              res_ok;
  logic [OFF_W-1:0]  res_off;
  logic [TIME_W-1:0] res_time;
  logic [LEN_W-1:0]  res_len;
  logic              out_valid;

  logic [NEED_W-1:0] need;
  logic [BB_W-1:0]   head_ins;
  logic [BB_W-1:0]   size_cl;
  logic [BB_W-1:0]   head_clr;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  probe_idx;
  logic [CNT_W-1:0]  ptr_dec;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  srbi_entry_t       ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  srbi_entry_t       ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  assign need = NEED_W'(len) + NEED_W'(INDEX_BYTES)
              + NEED_W'(count) * NEED_W'(INDEX_BYTES);
  assign head_ins  = head - BB_W'(len);
  assign size_cl   = (block_bytes > BLOCK_LIMIT) ? BLOCK_LIMIT : block_bytes;
  assign head_clr  = (size_cl >= BB_W'(HEADER_BYTES)) ?
                     size_cl - BB_W'(HEADER_BYTES) : '0;
  assign half      = span >> 1;
  assign probe_idx = lo + half;
  assign ptr_dec   = ptr - CNT_W'(1);

  assign sts.cmd        = cmd;
  assign sts.fits       = (count < CNT_W'(MAX_ENTRIES)) && (need <= NEED_W'(head));
  assign sts.pos_ok     = CNT_W'(pos) < count;
  assign sts.span_zero  = (span == '0);
  assign sts.shift_done = (ptr == lo);
  assign sts.out_free   = !out_valid || rsp.ready;

  always_comb begin
    ram_raddr = probe_idx[IDX_W-1:0];
    if (ctl.rd_issue) begin
      ram_raddr = IDX_W'(pos);
    end else if (ctl.shift) begin
      ram_raddr = ptr_dec[IDX_W-1:0];
    end
  end

  assign ram_we             = (ctl.shift && wr_pend) || ctl.place;
  assign ram_waddr          = ctl.place ? lo[IDX_W-1:0] : wr_addr;
  assign ram_wdata.rec_time = ctl.place ? key : ram_rdata.rec_time;
  assign ram_wdata.offset   = ctl.place ? res_off : ram_rdata.offset;
  assign ram_wdata.rec_len  = ctl.place ? len : ram_rdata.rec_len;
  assign ram_rdata          = srbi_entry_t'(ram_rbits);

  srbi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENTRY_W'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BB_RESET;
      count       <= '0;
      head        <= HEAD_RESET;
      wr_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        block_bytes <= cfg_wdata;
      end
      if (ctl.ins_start) begin
        head <= head_ins;
      end
      if (ctl.clear) begin
        count <= '0;
        head  <= head_clr;
      end
      if (ctl.place) begin
        count <= count + CNT_W'(1);
      end
      if (ctl.shift_init) begin
        wr_pend <= 1'b0;
      end else if (ctl.shift) begin
        wr_pend <= !sts.shift_done;
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= in_cmd;
      key <= in_time;
      len <= in_len;
      pos <= in_pos;
    end
    if (ctl.ins_start) begin
      res_ok   <= 1'b1;
      res_off  <= head_ins[OFF_W-1:0];
      res_time <= '0;
      res_len  <= '0;
      lo       <= '0;
      span     <= count;
    end
    if (ctl.res_zero || ctl.clear) begin
      res_ok   <= ctl.clear;
      res_off  <= '0;
      res_time <= '0;
      res_len  <= '0;
    end
    if (ctl.compare) begin
      if (ram_rdata.rec_time < key) begin
        lo   <= probe_idx + CNT_W'(1);
        span <= span - half - CNT_W'(1);
      end else begin
        span <= half;
      end
    end
    if (ctl.shift_init) begin
      ptr <= count;
    end else if (ctl.shift && !sts.shift_done) begin
      ptr     <= ptr_dec;
      wr_addr <= ptr[IDX_W-1:0];
    end
    if (ctl.rd_cap) begin
      res_ok   <= 1'b1;
      res_off  <= ram_rdata.offset;
      res_time <= ram_rdata.rec_time;
      res_len  <= ram_rdata.rec_len;
    end
    if (ctl.finish) begin
      rsp.ok          <= res_ok;
      rsp.data_offset <= res_off;
      rsp.out_time    <= res_time;
      rsp.out_len     <= res_len;
      rsp.entry_total <= TOT_W'(count);
    end
  end

  assign rsp.valid = out_valid;

endmodule

FILE: rtl/sorted_record_block_index.sv
// Sorted record block index: keeps the timestamp-ordered index of one storage
// block, taking insert, read and clear commands one at a time. An insert does a
// lower-bound binary search of the table (at most eight probes, each a table read
// followed by a compare), then moves each later entry up one place, one entry per
// cycle through the single-write, registered-read table memory. A finished
// result waits in the output register while the next request is taken. The
// block_bytes register takes effect only at the next clear; reset sets it back
// to 4096.
module sorted_record_block_index (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [srbi_pkg::BB_W-1:0] cfg_wdata,
  srbi_in_if.sink                   req,
  srbi_out_if.source                rsp
);
  import srbi_pkg::*;

  `include "sorted_record_block_index_assert.svh"

  srbi_ctl_t ctl;
  srbi_sts_t sts;

  srbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  srbi_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (req.cmd),
    .in_time   (req.rec_time),
    .in_len    (req.rec_len),
    .in_pos    (req.entry_pos),
    .ctl       (ctl),
    .sts       (sts),
    .rsp       (rsp)
  );

  `SRBI_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  `SRBI_ASSERT_NOW(a_total_in_range, rsp.valid, rsp.entry_total <= TOT_W'(MAX_ENTRIES))
  `SRBI_ASSERT_NOW(a_refused_zero, rsp.valid && !rsp.ok, (rsp.data_offset == '0) && (rsp.out_time == '0) && (rsp.out_len == '0))

endmodule
